FILE: rtl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the source character filter
// Result record passed from the front end to the back end, result kinds
// and the default sizes.
// ----------------------------------------------------------------------------
package scf_pkg;

	// default sizes
	localparam int MaxCommentDepthDefault = 15;
	localparam int CounterBitsDefault     = 32;

	// result record queue, a power of two
	localparam int QueueDepth = 4;

	// output field widths
	localparam int CharW = 8;
	localparam int KindW = 3;
	localparam int PosW  = 32;

	// result kinds
	localparam logic [KindW-1:0] KIND_CHAR        = 3'd0;
	localparam logic [KindW-1:0] KIND_END         = 3'd1;
	localparam logic [KindW-1:0] KIND_EOF_COMMENT = 3'd2;
	localparam logic [KindW-1:0] KIND_BAD_ESCAPE  = 3'd3;
	localparam logic [KindW-1:0] KIND_TOO_DEEP    = 3'd4;

	// characters of interest
	localparam logic [CharW-1:0] CH_OPEN  = 8'h28;
	localparam logic [CharW-1:0] CH_CLOSE = 8'h29;
	localparam logic [CharW-1:0] CH_BSLASH = 8'h5c;
	localparam logic [CharW-1:0] CH_LF    = 8'h0a;
	localparam logic [CharW-1:0] CH_CR    = 8'h0d;
	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_TAB   = 8'h09;

	// results of one input byte: an optional held space, then the main result
	typedef struct packed {
		logic             has_space;
		logic [CharW-1:0] char_out;
		logic [KindW-1:0] kind;
		logic [PosW-1:0]  line_number;
		logic [PosW-1:0]  column_number;
	} scf_rec_t;

endpackage

FILE: rtl/scf_front.sv
// ----------------------------------------------------------------------------
// scf_front: input side of the source character filter
// Takes one byte or end mark per beat, runs the escape and comment state
// machine, keeps the line and column counters and queues a result record.
// ----------------------------------------------------------------------------
module scf_front #(
	parameter int MAX_COMMENT_DEPTH = 15,
	parameter int COUNTER_BITS      = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [scf_pkg::CharW-1:0] char_in,
	input  logic                     end_of_input,
	input  logic                     q_full,
	output logic                     push,
	output scf_pkg::scf_rec_t        rec
);
	import scf_pkg::*;

	localparam int DepthW = $clog2(MAX_COMMENT_DEPTH + 1);
	localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_COMMENT_DEPTH);
	localparam logic [COUNTER_BITS-1:0] CountMax = '1;
	localparam logic [COUNTER_BITS-1:0] CountOne = COUNTER_BITS'(1);

	localparam logic [2:0] M_NORMAL  = 3'd0;
	localparam logic [2:0] M_ESCAPE  = 3'd1;
	localparam logic [2:0] M_COMMENT = 3'd2;
	localparam logic [2:0] M_CESCAPE = 3'd3;
	localparam logic [2:0] M_HALTED  = 3'd4;

	logic [2:0]              mode_q, mode_d;
	logic [DepthW-1:0]       depth_q, depth_d;
	logic                    space_q, space_d;
	logic [COUNTER_BITS-1:0] line_q, line_d, col_q, col_d;
	logic [COUNTER_BITS-1:0] line_inc, col_inc;
	logic                    emit, accept, white;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;

	// saturating increments
	assign line_inc = (line_q != CountMax) ? line_q + CountOne : line_q;
	assign col_inc  = (col_q != CountMax) ? col_q + CountOne : col_q;

	assign white = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);

	// next state and result of the current byte
	always_comb begin
		mode_d  = mode_q;
		depth_d = depth_q;
		space_d = space_q;
		line_d  = line_q;
		col_d   = col_q;
		emit    = 1'b0;
		rec.has_space = 1'b0;
		rec.char_out  = '0;
		rec.kind      = KIND_CHAR;
		unique case (mode_q)
			M_NORMAL: begin
				if (end_of_input) begin
					emit          = 1'b1;
					rec.has_space = space_q;
					rec.kind      = KIND_END;
					space_d       = 1'b0;
				end else begin
					if (char_in == CH_LF) begin
						line_d = line_inc;
						col_d  = CountOne;
					end else begin
						col_d = col_inc;
					end
					if (white) begin
						space_d = 1'b1;
					end else if (char_in == CH_OPEN) begin
						depth_d = DepthW'(1);
						space_d = 1'b1;
						mode_d  = M_COMMENT;
					end else if (char_in == CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else begin
						emit          = 1'b1;
						rec.has_space = space_q;
						rec.char_out  = char_in;
						space_d       = 1'b0;
					end
				end
			end
			M_COMMENT: begin
				if (end_of_input) begin
					emit     = 1'b1;
					rec.kind = KIND_EOF_COMMENT;
					mode_d   = M_HALTED;
				end else begin
					if (char_in == CH_LF) begin
						line_d = line_inc;
						col_d  = CountOne;
					end else begin
						col_d = col_inc;
					end
					if (char_in == CH_OPEN) begin
						if (depth_q >= DepthMax) begin
							emit     = 1'b1;
							rec.kind = KIND_TOO_DEEP;
							mode_d   = M_HALTED;
						end else begin
							depth_d = depth_q + DepthW'(1);
						end
					end else if (char_in == CH_CLOSE) begin
						depth_d = depth_q - DepthW'(1);
						if (depth_q == DepthW'(1)) begin
							mode_d  = M_NORMAL;
							space_d = 1'b1;
						end
					end else if (char_in == CH_BSLASH) begin
						mode_d = M_CESCAPE;
					end
				end
			end
			M_ESCAPE, M_CESCAPE: begin
				if (end_of_input) begin
					emit     = 1'b1;
					rec.kind = KIND_BAD_ESCAPE;
					mode_d   = M_HALTED;
				end else if (char_in == CH_CR || char_in == CH_LF) begin
					line_d = line_inc;
					col_d  = CountOne;
					mode_d = (mode_q == M_CESCAPE) ? M_COMMENT : M_NORMAL;
				end else if (char_in == CH_BSLASH || char_in == CH_OPEN) begin
					col_d = col_inc;
					if (mode_q == M_CESCAPE) begin
						mode_d = M_COMMENT;
					end else begin
						mode_d        = M_NORMAL;
						emit          = 1'b1;
						rec.has_space = space_q;
						rec.char_out  = char_in;
						space_d       = 1'b0;
					end
				end else begin
					emit     = 1'b1;
					rec.kind = KIND_BAD_ESCAPE;
					mode_d   = M_HALTED;
				end
			end
			default: begin
				// halted: beats are taken and dropped
				mode_d = M_HALTED;
			end
		endcase
		rec.line_number   = PosW'(line_d);
		rec.column_number = PosW'(col_d);
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_NORMAL;
			depth_q <= '0;
			space_q <= 1'b0;
			line_q  <= CountOne;
			col_q   <= CountOne;
		end else if (accept) begin
			mode_q  <= mode_d;
			depth_q <= depth_d;
			space_q <= space_d;
			line_q  <= line_d;
			col_q   <= col_d;
		end
	end

endmodule

FILE: rtl/scf_queue.sv
// ----------------------------------------------------------------------------
// scf_queue: result record queue
// Small register queue between front end and back end so either side can
// stall on its own.
// ----------------------------------------------------------------------------
module scf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scf_pkg::scf_rec_t wr_rec,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output scf_pkg::scf_rec_t rd_rec
);
	import scf_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	scf_rec_t          entry_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = (count_q == CntW'(QueueDepth));
	assign not_empty = (count_q != '0);
	assign rd_rec    = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

FILE: rtl/scf_back.sv
// ----------------------------------------------------------------------------
// scf_back: output side of the source character filter
// Expands each queued record into the held space beat, if any, and the main
// beat, through a registered output stage.
// ----------------------------------------------------------------------------
module scf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  scf_pkg::scf_rec_t         q_rec,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [scf_pkg::CharW-1:0] char_out,
	output logic [scf_pkg::KindW-1:0] kind,
	output logic [scf_pkg::PosW-1:0]  line_number,
	output logic [scf_pkg::PosW-1:0]  column_number,
	output logic                      last
);
	import scf_pkg::*;

	logic             valid_q, space_done_q, load, space_beat;
	logic [CharW-1:0] char_q;
	logic [KindW-1:0] kind_q;
	logic [PosW-1:0]  line_q, col_q;
	logic             last_q;

	assign load       = q_valid && (!valid_q || out_ready);
	assign space_beat = q_rec.has_space && !space_done_q;
	assign pop        = load && !space_beat;

	assign out_valid     = valid_q;
	assign char_out      = char_q;
	assign kind          = kind_q;
	assign line_number   = line_q;
	assign column_number = col_q;
	assign last          = last_q;

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			space_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q      <= 1'b1;
				space_done_q <= space_beat;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= space_beat ? CH_SPACE : q_rec.char_out;
			kind_q <= space_beat ? KIND_CHAR : q_rec.kind;
			line_q <= q_rec.line_number;
			col_q  <= q_rec.column_number;
			last_q <= !space_beat;
		end
	end

endmodule

FILE: rtl/source_char_filter.sv
// ----------------------------------------------------------------------------
// source_char_filter: source text character filter
// Collapses whitespace and nested parenthesis comments to one space, handles
// backslash escapes, tracks line and column and halts on errors until reset.
//
//   port group  dir  payload
//   s_*         in   tdata[7:0] char_in, tlast end_of_input
//   m_*         out  tdata char_out/line/column, tuser kind, tlast last
//
// One input beat is taken per cycle while the result queue has room.
// An input gives zero, one or two output beats; the output register sends
// one beat per cycle while m_tready is high, so only a byte that releases
// a held space costs an extra beat. Records pass the queue, then the output
// register. Reset clears filter state, counters, queue and output stage.
// ----------------------------------------------------------------------------
module source_char_filter #(
	parameter int MAX_COMMENT_DEPTH = scf_pkg::MaxCommentDepthDefault,
	parameter int COUNTER_BITS      = scf_pkg::CounterBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [7:0] char_out, [39:8] line_number, [71:40] column_number
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast    // last
);
	import scf_pkg::*;

	logic             push, q_full, pop, q_valid;
	scf_rec_t         wr_rec, rd_rec;
	logic [CharW-1:0] char_out;
	logic [PosW-1:0]  line_number, column_number;

	// front end: classify and count
	scf_front #(
		.MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH),
		.COUNTER_BITS(COUNTER_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.char_in(s_tdata),
		.end_of_input(s_tlast),
		.q_full(q_full),
		.push(push),
		.rec(wr_rec)
	);

	// record queue
	scf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_rec(wr_rec),
		.full(q_full),
		.pop(pop),
		.not_empty(q_valid),
		.rd_rec(rd_rec)
	);

	// back end: beat expansion
	scf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_rec(rd_rec),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.char_out(char_out),
		.kind(m_tuser),
		.line_number(line_number),
		.column_number(column_number),
		.last(m_tlast)
	);

	assign m_tdata = {column_number, line_number, char_out};

endmodule
